FILE: src/spac_pkg.sv
// Shared types, constants and opcodes for the spectrum path assignment checker.
package spac_pkg;

	localparam int MAX_EDGES_DEF    = 1024;
	localparam int MAX_NODES_DEF    = 256;
	localparam int MAX_CHANNELS_DEF = 64;
	localparam int PATH_LIMIT_RST   = 25000;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 15;

	localparam logic [CFG_AW-1:0] REG_NODE_COUNT    = 2'd0;
	localparam logic [CFG_AW-1:0] REG_EDGE_COUNT    = 2'd1;
	localparam logic [CFG_AW-1:0] REG_CHANNEL_COUNT = 2'd2;
	localparam logic [CFG_AW-1:0] REG_PATH_LIMIT    = 2'd3;

	localparam logic [16:0] SLOT_MAX = 17'h1FFFF;

	localparam logic [2:0] OP_LOAD    = 3'd0;
	localparam logic [2:0] OP_BEGIN   = 3'd1;
	localparam logic [2:0] OP_CHANNEL = 3'd2;
	localparam logic [2:0] OP_PATH    = 3'd3;
	localparam logic [2:0] OP_QUERY   = 3'd4;

	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_CHAN_RNG = 4'd1;
	localparam logic [3:0] ST_NOT_CONT = 4'd2;
	localparam logic [3:0] ST_PATH_LNG = 4'd3;
	localparam logic [3:0] ST_EDGE_IDX = 4'd4;
	localparam logic [3:0] ST_DISCONT  = 4'd5;
	localparam logic [3:0] ST_WRONG_END = 4'd6;
	localparam logic [3:0] ST_CONFLICT = 4'd7;
	localparam logic [3:0] ST_ENDPOINT = 4'd8;

	// One item as it travels from the front end to the back end
	typedef struct packed {
		logic [2:0] opcode;
		logic [9:0] edge_index;
		logic [7:0] node_a;
		logic [7:0] node_b;
		logic [6:0] channel_number;
		logic       last_edge;
	} item_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_EXEC
	} bk_state_t;

	// Result of one item
	typedef struct packed {
		logic [3:0]  status;
		logic [16:0] used_slots;
	} result_t;

endpackage

FILE: src/spac_front.sv
// Front end: item input queue with a two-entry buffer toward the back end.
module spac_front
	import spac_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t in_item,
	output logic  avail,
	output item_t head,
	input  logic  take
);

	item_t      buf_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign head  = buf_q[rd_q];

	// Payload storage
	always_ff @(posedge clk) begin
		if (push && !full)
			buf_q[wr_q] <= in_item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full)
				wr_q <= ~wr_q;
			if (take && avail)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((take && avail) ? 1 : 0);
		end
	end

endmodule

FILE: src/spac_back.sv
// Back end: edge table, occupancy memory, task state and result register.
module spac_back
	import spac_pkg::*;
#(
	parameter int MAX_EDGES    = MAX_EDGES_DEF,
	parameter int MAX_NODES    = MAX_NODES_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        avail,
	input  item_t       head,
	output logic        take,
	input  logic [8:0]  node_count,
	input  logic [10:0] edge_count,
	input  logic [6:0]  channel_count,
	input  logic [14:0] path_limit,
	output logic        empty,
	input  logic        pop,
	output result_t     res
);

	localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

	logic [15:0] ends_mem [MAX_EDGES];
	logic [63:0] occ_mem  [MAX_EDGES];

	bk_state_t st_q, st_d;
	logic [EW-1:0] clr_q;
	item_t  it_q;
	logic [15:0] ends_rd_q;
	logic [63:0] occ_rd_q;

	logic [7:0]  walk_node_q, task_target_q;
	logic [5:0]  first_channel_q, prev_channel_q;
	logic [6:0]  channels_taken_q;
	logic        have_channel_q, self_loop_q;
	logic [14:0] path_length_q;
	logic [16:0] slot_total_q;
	logic [3:0]  first_error_q;
	logic        res_full_q;
	result_t     res_q;

	logic        idx_ok;
	logic [EW-1:0] idx;
	logic [3:0]  err;
	logic [7:0]  next_node;
	logic [63:0] mask;
	logic [17:0] slot_sum;
	logic [16:0] slot_sat, slot_new;
	logic        occ_wr;

	assign idx    = EW'(it_q.edge_index);
	assign idx_ok = ({1'b0, it_q.edge_index} < edge_count) &&
		(32'(it_q.edge_index) < MAX_EDGES);
	assign empty  = !res_full_q;
	assign res    = res_q;
	assign take   = (st_q == BK_IDLE) && avail;

	// Slot count after a marking path edge, saturated
	assign slot_sat = (slot_sum > {1'b0, SLOT_MAX}) ? SLOT_MAX : slot_sum[16:0];
	assign slot_new = (it_q.opcode == OP_PATH && !self_loop_q) ? slot_sat : slot_total_q;

	// Channel mask of the current task
	always_comb begin
		if (channels_taken_q == 7'd0)
			mask = '0;
		else if (channels_taken_q >= 7'd64)
			mask = '1;
		else
			mask = ((64'd1 << channels_taken_q) - 64'd1) << first_channel_q;
	end

	// Error classification of the item in execution
	always_comb begin
		err       = ST_OK;
		next_node = walk_node_q;
		occ_wr    = 1'b0;
		slot_sum  = {1'b0, slot_total_q} + 18'(channels_taken_q);
		case (it_q.opcode)
			OP_LOAD: begin
				if ({1'b0, it_q.node_a} >= node_count || {1'b0, it_q.node_b} >= node_count ||
					32'(it_q.node_a) >= MAX_NODES || 32'(it_q.node_b) >= MAX_NODES)
					err = ST_ENDPOINT;
			end
			OP_CHANNEL: begin
				if (it_q.channel_number >= channel_count ||
					32'(it_q.channel_number) >= MAX_CHANNELS)
					err = ST_CHAN_RNG;
				else if (have_channel_q &&
					it_q.channel_number != 7'(prev_channel_q) + 7'd1)
					err = ST_NOT_CONT;
			end
			OP_PATH: begin
				if (path_length_q + 15'd1 > path_limit || path_length_q == 15'h7FFF)
					err = ST_PATH_LNG;
				else if (!idx_ok)
					err = ST_EDGE_IDX;
				else if (!self_loop_q) begin
					if (ends_rd_q[15:8] == walk_node_q)
						next_node = ends_rd_q[7:0];
					else if (ends_rd_q[7:0] == walk_node_q)
						next_node = ends_rd_q[15:8];
					else
						err = ST_DISCONT;
					if (err == ST_OK && it_q.last_edge && next_node != task_target_q)
						err = ST_WRONG_END;
					else if (err == ST_OK && (occ_rd_q & mask) != '0)
						err = ST_CONFLICT;
					occ_wr = (err == ST_OK);
				end
			end
			default: ;
		endcase
	end

	// Sequencer
	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_CLEAR: if (32'(clr_q) == MAX_EDGES - 1) st_d = BK_IDLE;
			BK_IDLE:  if (avail) st_d = BK_READ;
			BK_READ:  st_d = BK_EXEC;
			BK_EXEC:  if (!res_full_q || pop) st_d = BK_IDLE;
			default:  st_d = BK_IDLE;
		endcase
	end

	// Memories: reads registered in the read state ahead of execution, writes on execution or clear sweep
	always_ff @(posedge clk) begin
		if (st_q == BK_IDLE && avail)
			it_q <= head;
		if (st_q == BK_READ) begin
			ends_rd_q <= ends_mem[idx];
			occ_rd_q  <= occ_mem[idx];
		end
		if (st_q == BK_CLEAR)
			occ_mem[clr_q] <= '0;
		else if (st_q == BK_EXEC && st_d == BK_IDLE && first_error_q == ST_OK) begin
			if (occ_wr)
				occ_mem[idx] <= occ_rd_q | mask;
			if (it_q.opcode == OP_LOAD && err == ST_OK && 32'(it_q.edge_index) < MAX_EDGES)
				ends_mem[idx] <= {it_q.node_a, it_q.node_b};
		end
	end

	// Task state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q             <= BK_CLEAR;
			clr_q            <= '0;
			walk_node_q      <= '0;
			task_target_q    <= '0;
			first_channel_q  <= '0;
			prev_channel_q   <= '0;
			channels_taken_q <= '0;
			have_channel_q   <= 1'b0;
			self_loop_q      <= 1'b0;
			path_length_q    <= '0;
			slot_total_q     <= '0;
			first_error_q    <= ST_OK;
			res_full_q       <= 1'b0;
			res_q            <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == BK_CLEAR)
				clr_q <= clr_q + EW'(1);
			if (st_q == BK_EXEC && st_d == BK_IDLE)
				res_full_q <= 1'b1;
			else if (pop && res_full_q)
				res_full_q <= 1'b0;
			if (st_q == BK_EXEC && st_d == BK_IDLE) begin
				if (first_error_q != ST_OK) begin
					res_q <= '{status: first_error_q, used_slots: slot_total_q};
				end else if (err != ST_OK) begin
					first_error_q <= err;
					res_q <= '{status: err, used_slots: slot_total_q};
				end else begin
					res_q <= '{status: ST_OK, used_slots: slot_new};
					case (it_q.opcode)
						OP_BEGIN: begin
							walk_node_q      <= it_q.node_a;
							task_target_q    <= it_q.node_b;
							self_loop_q      <= (it_q.node_a == it_q.node_b);
							have_channel_q   <= 1'b0;
							channels_taken_q <= '0;
							first_channel_q  <= '0;
							prev_channel_q   <= '0;
							path_length_q    <= '0;
						end
						OP_CHANNEL: begin
							prev_channel_q <= it_q.channel_number[5:0];
							if (have_channel_q) begin
								channels_taken_q <= channels_taken_q + 7'd1;
							end else begin
								first_channel_q  <= it_q.channel_number[5:0];
								channels_taken_q <= 7'd1;
								have_channel_q   <= 1'b1;
							end
						end
						OP_PATH: begin
							path_length_q <= path_length_q + 15'd1;
							if (!self_loop_q) begin
								walk_node_q  <= next_node;
								slot_total_q <= slot_sat;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

endmodule

FILE: src/spectrum_path_assignment_checker.sv
// Top level of the spectrum path assignment checker.
// An item accepted by the back end passes through its read and execute states.
// The next item is taken only after the last leaves execution, held while a result waits.
// The input queue holds two items, so push continues while the back end works.
// Reset: asynchronous; after it the occupancy memory is swept clear over all MAX_EDGES
// entries (1024 by default) before the first item is executed.
module spectrum_path_assignment_checker
	import spac_pkg::*;
#(
	parameter int MAX_EDGES    = MAX_EDGES_DEF,
	parameter int MAX_NODES    = MAX_NODES_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [2:0]        opcode,
	input  logic [9:0]        edge_index,
	input  logic [7:0]        node_a,
	input  logic [7:0]        node_b,
	input  logic [6:0]        channel_number,
	input  logic              last_edge,
	output logic              empty,
	input  logic              pop,
	output logic [3:0]        status,
	output logic [16:0]       used_slots,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	item_t   in_item, head;
	logic    avail, take;
	result_t res;
	logic [8:0]  node_count_q;
	logic [10:0] edge_count_q;
	logic [6:0]  channel_count_q;
	logic [14:0] path_limit_q;

	assign in_item = '{opcode: opcode, edge_index: edge_index, node_a: node_a,
		node_b: node_b, channel_number: channel_number, last_edge: last_edge};
	assign status     = res.status;
	assign used_slots = res.used_slots;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q    <= 9'd256;
			edge_count_q    <= 11'd1024;
			channel_count_q <= 7'd64;
			path_limit_q    <= 15'(PATH_LIMIT_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NODE_COUNT:    node_count_q    <= cfg_data[8:0];
				REG_EDGE_COUNT:    edge_count_q    <= cfg_data[10:0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[6:0];
				REG_PATH_LIMIT:    path_limit_q    <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	spac_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.avail(avail), .head(head), .take(take)
	);

	spac_back #(
		.MAX_EDGES(MAX_EDGES), .MAX_NODES(MAX_NODES), .MAX_CHANNELS(MAX_CHANNELS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .avail(avail), .head(head), .take(take),
		.node_count(node_count_q), .edge_count(edge_count_q),
		.channel_count(channel_count_q), .path_limit(path_limit_q),
		.empty(empty), .pop(pop), .res(res)
	);

endmodule

FILE: src/spac_checker.sv
// Port-level checker for the spectrum path assignment checker, with its bind.
module spac_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [3:0]  status,
	input logic [16:0] used_slots
);

	// A latched error never clears while results are shown
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && status != 4'd0) ##1 !empty |-> status == $past(status, 1) ||
		status != 4'd0) else $error("error status cleared");

	// Status stays within its codes
	a_status_rng: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> status <= 4'd8) else $error("status out of range");

	// A waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(used_slots) && $stable(status)))
		else $error("result changed while waiting");

endmodule

bind spectrum_path_assignment_checker spac_checker u_spac_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.status(status), .used_slots(used_slots)
);
